>>> hdl/tbef_pkg.sv
package tbef_pkg;

  localparam int IN_W  = 32;
  localparam int CFG_W = 47;
  localparam int OUT_W = 48;

  // quotient bits of each divider, plus one stage for the overflow check
  localparam int QW      = CFG_W;
  localparam int DIV_LAT = QW + 1;

  localparam logic [CFG_W-1:0] SAT = {CFG_W{1'b1}};

  typedef enum logic [1:0] {
    REG_PRELOAD     = 2'd0,
    REG_RATE        = 2'd1,
    REG_PROGRESSION = 2'd2,
    REG_MAX_FORCE   = 2'd3
  } cfg_idx_t;

endpackage

>>> hdl/torsion_bar_equivalent_force.sv
// Pipeline: 4 front stages, 48 divider stages, 5 back stages from input to result;
//   the three dividers retire one quotient bit per stage.
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// Reset: rst clears all valid bits and loads the register defaults
//   (preload 0, rate 1.0, progression 0, max force 1.0).
module torsion_bar_equivalent_force #(
  parameter int ANGLE_FRAC_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [95:0]                   s_tdata,   // twist_angle, reference_ratio, current_ratio
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // preload_torque, bar_stiffness, bar_progression, spring_torque, wheel_force
  output logic [239:0]                  m_tdata,
  output logic [0:0]                    m_tuser,   // valid_res
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  tbef_pkg::cfg_idx_t            cfg_index,
  input  logic [tbef_pkg::CFG_W-1:0]    cfg_data
);
  import tbef_pkg::*;

  localparam int A = ANGLE_FRAC_BITS;
  localparam logic [31:0] MIN_RATIO = 32'((64'd1 << A) / 64'd1000000);

  typedef struct packed {
    logic        inv;
    logic        tneg;
    logic [31:0] tm;
    logic [31:0] c;
    logic [62:0] tt;
  } meta_t;

  function automatic logic [CFG_W-1:0] clamp47(input logic [127:0] x,
                                                input logic [CFG_W-1:0] lim);
    if (x > {81'b0, lim}) return lim;
    return x[CFG_W-1:0];
  endfunction

  logic [CFG_W-1:0] wheel_preload, wheel_rate, wheel_progression, max_wheel_force;
  logic en;

  assign en        = !m_tvalid || m_tready;
  assign s_tready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_preload     <= '0;
      wheel_rate        <= CFG_W'(65536);
      wheel_progression <= '0;
      max_wheel_force   <= CFG_W'(65536);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PRELOAD:     wheel_preload     <= cfg_data;
        REG_RATE:        wheel_rate        <= cfg_data;
        REG_PROGRESSION: wheel_progression <= cfg_data;
        REG_MAX_FORCE:   max_wheel_force   <= cfg_data;
        default:         wheel_preload     <= wheel_preload;
      endcase
    end
  end

  // input decode
  logic [31:0] twist, rref, rcur, tm_in, r_in, c_in;
  logic        inv_in;

  assign twist  = s_tdata[31:0];
  assign rref   = s_tdata[63:32];
  assign rcur   = s_tdata[95:64];
  assign tm_in  = twist[31] ? 32'(-twist) : twist;
  assign r_in   = rref[31]  ? 32'(-rref)  : rref;
  assign c_in   = rcur[31]  ? 32'(-rcur)  : rcur;
  assign inv_in = (wheel_rate == '0) || (max_wheel_force == '0) ||
                  (r_in <= MIN_RATIO) || (c_in <= MIN_RATIO);

  // front stages: square and cube of the reference ratio, square of the twist magnitude
  logic        v0, v1, v2, v3;
  meta_t       m0, m1, m2, m3;
  logic [31:0] r0, r1, r_2, r_3;
  logic [63:0] r2_1, r2_2, r2_3;
  logic [93:0] r3_3;
  logic [127:0] r3p;

  tbef_mul u_mul_r3 (.clk(clk), .en(en), .a(r2_1), .b({32'b0, r1}), .p(r3p));

  // divider section
  logic             dv [0:DIV_LAT-1];
  meta_t            dm [0:DIV_LAT-1];
  logic [CFG_W-1:0] pre_d, stf_d, prg_d;

  tbef_div #(.SH(A), .DW(32)) u_div_pre (
    .clk(clk), .en(en), .num(wheel_preload), .den(r_3), .quo(pre_d));
  tbef_div #(.SH(2*A), .DW(64)) u_div_stf (
    .clk(clk), .en(en), .num(wheel_rate), .den(r2_3), .quo(stf_d));
  tbef_div #(.SH(3*A), .DW(94)) u_div_prg (
    .clk(clk), .en(en), .num(wheel_progression), .den(r3_3), .quo(prg_d));

  // back stages
  logic             v4, v5, v6, v7, v8;
  meta_t            m4, m5, m6, m7;
  logic [CFG_W-1:0] pre4, stf4, prg4, pre5, stf5, prg5, t1_5, t2_5;
  logic [CFG_W-1:0] pre6, stf6, prg6, pre7, stf7, prg7;
  logic [127:0]     p1, p2, pf;
  logic [47:0]      sum6, smag6, sum7;
  logic             sneg6, sneg7;

  tbef_mul u_mul_t1 (.clk(clk), .en(en), .a({17'b0, stf_d}),
                     .b({32'b0, dm[DIV_LAT-1].tm}), .p(p1));
  tbef_mul u_mul_t2 (.clk(clk), .en(en), .a({17'b0, prg_d}),
                     .b({1'b0, dm[DIV_LAT-1].tt}), .p(p2));
  tbef_mul u_mul_f  (.clk(clk), .en(en), .a({16'b0, smag6}),
                     .b({32'b0, m6.c}), .p(pf));

  // spring torque sum with saturation
  logic [47:0]        st;
  logic signed [49:0] sp, sw;
  logic [47:0]        sum_s;

  assign st = {1'b0, t1_5} + {1'b0, t2_5};
  assign sp = $signed({3'b0, pre5});
  assign sw = m5.tneg ? sp - $signed({2'b0, st}) : sp + $signed({2'b0, st});

  always_comb begin
    priority if (sw > $signed({3'b0, SAT}))
      sum_s = {1'b0, SAT};
    else if (sw < -$signed({3'b0, SAT}) - 50'sd1)
      sum_s = {1'b1, {CFG_W{1'b0}}};
    else
      sum_s = sw[47:0];
  end

  logic [CFG_W-1:0] fm;
  logic [47:0]      force_s;

  assign fm      = clamp47(pf >> A, max_wheel_force);
  assign force_s = sneg7 ? 48'(-{1'b0, fm}) : {1'b0, fm};

  logic [47:0] o_pre, o_stf, o_prg, o_sum, o_force;
  logic        o_valid_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0; v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
      v4 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0; v7 <= 1'b0; v8 <= 1'b0;
      for (int k = 0; k < DIV_LAT; k++) dv[k] <= 1'b0;
    end else if (en) begin
      v0 <= s_tvalid;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      dv[0] <= v3;
      for (int k = 1; k < DIV_LAT; k++) dv[k] <= dv[k-1];
      v4 <= dv[DIV_LAT-1];
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m0 <= '{inv: inv_in, tneg: twist[31], tm: tm_in, c: c_in, tt: '0};
      r0 <= r_in;

      m1   <= '{inv: m0.inv, tneg: m0.tneg, tm: m0.tm, c: m0.c,
                tt: 63'(64'(m0.tm) * 64'(m0.tm))};
      r1   <= r0;
      r2_1 <= 64'(r0) * 64'(r0);

      m2   <= m1;
      r_2  <= r1;
      r2_2 <= r2_1;

      m3   <= m2;
      r_3  <= r_2;
      r2_3 <= r2_2;
      r3_3 <= r3p[93:0];

      dm[0] <= m3;
      for (int k = 1; k < DIV_LAT; k++) dm[k] <= dm[k-1];

      m4   <= dm[DIV_LAT-1];
      pre4 <= pre_d;
      stf4 <= stf_d;
      prg4 <= prg_d;

      m5   <= m4;
      pre5 <= pre4;
      stf5 <= stf4;
      prg5 <= prg4;
      t1_5 <= clamp47(p1 >> A, SAT);
      t2_5 <= clamp47(p2 >> (2*A + 1), SAT);

      m6    <= m5;
      pre6  <= pre5;
      stf6  <= stf5;
      prg6  <= prg5;
      sum6  <= sum_s;
      sneg6 <= sum_s[47];
      smag6 <= sum_s[47] ? 48'(-sum_s) : sum_s;

      m7    <= m6;
      pre7  <= pre6;
      stf7  <= stf6;
      prg7  <= prg6;
      sum7  <= sum6;
      sneg7 <= sneg6;

      // invalid items report zeros
      o_valid_res <= !m7.inv;
      o_pre   <= m7.inv ? '0 : {1'b0, pre7};
      o_stf   <= m7.inv ? '0 : {1'b0, stf7};
      o_prg   <= m7.inv ? '0 : {1'b0, prg7};
      o_sum   <= m7.inv ? '0 : sum7;
      o_force <= m7.inv ? '0 : force_s;
    end
  end

  assign m_tvalid = v8;
  assign m_tdata  = {o_force, o_sum, o_prg, o_stf, o_pre};
  assign m_tuser  = o_valid_res;

endmodule

>>> hdl/tbef_div.sv
// floor(num * 2^SH / den), saturated to all ones; one quotient bit per stage
module tbef_div #(
  parameter int SH = 24,
  parameter int DW = 32
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [tbef_pkg::QW-1:0]   num,
  input  logic [DW-1:0]             den,
  output logic [tbef_pkg::QW-1:0]   quo
);
  import tbef_pkg::*;

  localparam int NW = QW + SH;
  localparam int CW = (SH > DW) ? SH : DW;

  logic [NW-1:0] nfull;
  logic [SH-1:0] hi;
  logic          ovf0;

  logic [DW-1:0] rem_q [0:QW];
  logic [QW-1:0] lo_q  [0:QW];
  logic [DW-1:0] den_q [0:QW];
  logic [QW-1:0] q_q   [0:QW];
  logic          ovf_q [0:QW];

  assign nfull = {num, {SH{1'b0}}};
  assign hi    = nfull[NW-1:QW];
  // quotient would need more than QW bits
  assign ovf0  = CW'(hi) >= CW'(den);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0] <= ovf0 ? '0 : DW'(hi);
      lo_q[0]  <= nfull[QW-1:0];
      den_q[0] <= den;
      q_q[0]   <= '0;
      ovf_q[0] <= ovf0;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_stage
    logic [DW:0] trial;
    logic        ge;
    logic [DW:0] diff;

    assign trial = {rem_q[k-1], lo_q[k-1][QW-1]};
    assign ge    = trial >= {1'b0, den_q[k-1]};
    assign diff  = trial - {1'b0, den_q[k-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        lo_q[k]  <= lo_q[k-1] << 1;
        den_q[k] <= den_q[k-1];
        q_q[k]   <= {q_q[k-1][QW-2:0], ge};
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  assign quo = ovf_q[QW] ? SAT : q_q[QW];

endmodule

>>> hdl/tbef_mul.sv
// 64x64 multiply as four registered 32x32 partial products, summed after the register
module tbef_mul (
  input  logic         clk,
  input  logic         en,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic [127:0] p
);
  logic [63:0] pp00, pp01, pp10, pp11;

  always_ff @(posedge clk) begin
    if (en) begin
      pp00 <= 64'(a[31:0])  * 64'(b[31:0]);
      pp01 <= 64'(a[31:0])  * 64'(b[63:32]);
      pp10 <= 64'(a[63:32]) * 64'(b[31:0]);
      pp11 <= 64'(a[63:32]) * 64'(b[63:32]);
    end
  end

  assign p = {64'b0, pp00} + {32'b0, pp01, 32'b0} + {32'b0, pp10, 32'b0} + {pp11, 64'b0};

endmodule

>>> bench/tb_torsion_bar_equivalent_force.sv
`timescale 1ns / 1ps

module tb_torsion_bar_equivalent_force;
  import tbef_pkg::*;

  localparam int FRAC = 24;
  localparam int LAT  = 57;
  localparam logic [127:0] MIN_RATIO = 128'd16;

  typedef struct packed {
    logic              valid_res;
    logic [OUT_W-1:0]  preload_torque;
    logic [OUT_W-1:0]  bar_stiffness;
    logic [OUT_W-1:0]  bar_progression;
    logic [OUT_W-1:0]  spring_torque;
    logic [OUT_W-1:0]  wheel_force;
  } force_res_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [95:0]       s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [239:0]      m_tdata;
  logic [0:0]        m_tuser;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  cfg_idx_t          cfg_index = REG_PRELOAD;
  logic [CFG_W-1:0]  cfg_data = '0;

  // shadow copy of the block's registers
  logic [CFG_W-1:0]  sh_preload, sh_rate, sh_prog, sh_max;

  force_res_t        pending_forces[$];
  int                errors = 0;
  int                send_idle_pct = 0;
  int                stall_pct = 0;
  longint            cycle_cnt = 0;
  longint            hold_until = 0;

  torsion_bar_equivalent_force uut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb_torsion_bar_equivalent_force: errors");
    $finish;
  end

  function automatic logic [127:0] mag32(logic [31:0] v);
    return v[31] ? 128'(33'h1_0000_0000 - 33'(v)) : 128'(v);
  endfunction

  function automatic logic [127:0] clamp(logic [127:0] v, logic [127:0] lim);
    return (v > lim) ? lim : v;
  endfunction

  function automatic force_res_t predict_force(logic [95:0] d);
    force_res_t   res;
    logic [127:0] tm, r, c, pre, stf, prg, t1, t2, smag, fm;
    longint       sum;
    logic         neg;
    res = '0;
    tm = mag32(d[31:0]);
    r  = mag32(d[63:32]);
    c  = mag32(d[95:64]);
    if (sh_rate == 0 || sh_max == 0 || r <= MIN_RATIO || c <= MIN_RATIO)
      return res;
    pre = clamp((128'(sh_preload) << FRAC) / r, 128'(SAT));
    stf = clamp((128'(sh_rate) << (2 * FRAC)) / (r * r), 128'(SAT));
    prg = clamp((128'(sh_prog) << (3 * FRAC)) / (r * r * r), 128'(SAT));
    t1 = clamp((stf * tm) >> FRAC, 128'(SAT));
    t2 = clamp((prg * tm * tm) >> (2 * FRAC + 1), 128'(SAT));
    sum = longint'(pre[63:0]);
    if (d[31]) sum = sum - longint'(t1[63:0]) - longint'(t2[63:0]);
    else sum = sum + longint'(t1[63:0]) + longint'(t2[63:0]);
    if (sum > longint'(SAT)) sum = longint'(SAT);
    if (sum < -longint'(SAT) - 1) sum = -longint'(SAT) - 1;
    neg  = sum < 0;
    smag = neg ? 128'(-sum) : 128'(sum);
    fm   = clamp((smag * c) >> FRAC, 128'(sh_max));
    res.valid_res       = 1'b1;
    res.preload_torque  = pre[47:0];
    res.bar_stiffness   = stf[47:0];
    res.bar_progression = prg[47:0];
    res.spring_torque   = 48'(sum);
    res.wheel_force     = neg ? -fm[47:0] : fm[47:0];
    return res;
  endfunction

  // register shadow and expectations, both taken at the transfer edge
  always @(posedge clk) begin
    if (rst) begin
      sh_preload <= '0;
      sh_rate    <= 47'd65536;
      sh_prog    <= '0;
      sh_max     <= 47'd65536;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PRELOAD:     sh_preload <= cfg_data;
          REG_RATE:        sh_rate    <= cfg_data;
          REG_PROGRESSION: sh_prog    <= cfg_data;
          REG_MAX_FORCE:   sh_max     <= cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) pending_forces.push_back(predict_force(s_tdata));
    end
  end

  task automatic check_field(string name, logic [47:0] exp_v, logic [47:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t %s mismatch: expected %h actual %h", $realtime, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    force_res_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_forces.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none actual %h/%h", $realtime,
                 m_tuser, m_tdata);
      end else begin
        exp_r = pending_forces.pop_front();
        check_field("valid_res", 48'(exp_r.valid_res), 48'(m_tuser[0]));
        check_field("preload_torque", exp_r.preload_torque, m_tdata[47:0]);
        check_field("bar_stiffness", exp_r.bar_stiffness, m_tdata[95:48]);
        check_field("bar_progression", exp_r.bar_progression, m_tdata[143:96]);
        check_field("spring_torque", exp_r.spring_torque, m_tdata[191:144]);
        check_field("wheel_force", exp_r.wheel_force, m_tdata[239:192]);
      end
    end
  end

  // receiver: random stalls, plus a long hold-off when requested
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt < hold_until) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_item(logic [31:0] twist, logic [31:0] ref_r, logic [31:0] cur_r);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {cur_r, ref_r, twist};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_forces.size() != 0) @(posedge clk);
    repeat (LAT + 5) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(logic [CFG_W-1:0] pre, rate, prog, maxf);
    write_reg(REG_PRELOAD, pre);
    write_reg(REG_RATE, rate);
    write_reg(REG_PROGRESSION, prog);
    write_reg(REG_MAX_FORCE, maxf);
  endtask

  function automatic logic [31:0] rand_ratio();
    logic [31:0] v;
    case ($urandom_range(5))
      0: v = $urandom;
      1: v = $urandom_range(40);
      2: v = 32'h0100_0000 + $urandom_range(32'h00FF_FFFF) - 32'h0080_0000;
      3: v = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: v = $urandom_range(32'h1000_0000, 32'h0010_0000);
    endcase
    return $urandom_range(1) ? -v : v;
  endfunction

  function automatic logic [31:0] rand_twist();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(32'h0200_0000)) - 32'sh0100_0000);
      2: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return 32'($signed($urandom_range(2000)) - 1000);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] rand_reg();
    case ($urandom_range(3))
      0: return 47'({$urandom, $urandom} >> 17);
      1: return 47'($urandom_range(32'h00FF_FFFF));
      2: return SAT;
      default: return 47'($urandom) << $urandom_range(16);
    endcase
  endfunction

  task automatic test_directed();
    logic [31:0] twists[6] = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                               32'h1, 32'h0100_0000};
    logic [31:0] ratios[8] = '{32'h0100_0000, 32'd17, 32'd16, 32'h8000_0000,
                               32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFEF, 32'hFFFF_FFF0};
    set_regs(47'h0010_0000, 47'h0100_0000, 47'h0004_0000, 47'h1_0000_0000);
    foreach (twists[i]) send_item(twists[i], 32'h0100_0000, 32'h0100_0000);
    foreach (ratios[i]) send_item(32'h0080_0000, ratios[i], 32'h0100_0000);
    foreach (ratios[i]) send_item(32'hFF80_0000, 32'h0100_0000, ratios[i]);
  endtask

  task automatic test_reg_extremes();
    set_regs(SAT, SAT, SAT, SAT);
    send_item(32'h7FFF_FFFF, 32'd17, 32'h8000_0000);
    send_item(32'h8000_0000, 32'd17, 32'h7FFF_FFFF);
    send_item(32'h0100_0000, 32'h8000_0000, 32'h8000_0000);
    set_regs(47'd0, 47'd1, 47'd0, 47'd1);
    send_item(32'h7FFF_FFFF, 32'd17, 32'h8000_0000);
    send_item(32'h8000_0000, 32'h0100_0000, 32'h0100_0000);
    // a zero rate or a zero force limit voids every item
    set_regs(SAT, 47'd0, SAT, SAT);
    send_item(32'h0100_0000, 32'h0100_0000, 32'h0100_0000);
    set_regs(SAT, SAT, SAT, 47'd0);
    send_item(32'h0100_0000, 32'h0100_0000, 32'h0100_0000);
  endtask

  task automatic test_random(int n, int idle, int stall);
    send_idle_pct = idle;
    stall_pct = stall;
    for (int p = 0; p < 2; p++) begin
      set_regs(rand_reg(), rand_reg(), rand_reg(), rand_reg());
      for (int i = 0; i < n / 2; i++) send_item(rand_twist(), rand_ratio(), rand_ratio());
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    set_regs(47'h0100_0000, 47'h0200_0000, 47'h0080_0000, 47'h7FFF_0000);
    hold_until = cycle_cnt + 300;
    for (int i = 0; i < 120; i++) send_item(rand_twist(), rand_ratio(), rand_ratio());
    // sender waits for the pipeline to empty before going on
    drain();
    for (int i = 0; i < 20; i++) send_item(rand_twist(), rand_ratio(), rand_ratio());
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // defaults after reset
    send_item(32'h0100_0000, 32'h0100_0000, 32'h0100_0000);
    send_item(32'hFF00_0000, 32'h8000_0000, 32'h0200_0000);
    test_directed();
    test_reg_extremes();
    test_random(100, 0, 0);
    test_random(100, 47, 0);
    test_random(100, 0, 47);
    test_random(100, 20, 20);
    test_backpressure();
    drain();
    if (errors == 0) begin
      $display("tb_torsion_bar_equivalent_force: clean");
    end else begin
      $display("tb_torsion_bar_equivalent_force: errors");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/tbef_pkg.sv
hdl/tbef_div.sv
hdl/tbef_mul.sv
hdl/torsion_bar_equivalent_force.sv
bench/tb_torsion_bar_equivalent_force.sv
